@@ rtl/brft_pkg.sv @@
package brft_pkg;

	localparam int WORD_BITS_DEF  = 32;
	localparam int TILE_WORDS_DEF = 8;
	localparam int GRID_MAX_X_DEF = 1024;
	localparam int GRID_MAX_Y_DEF = 1024;

	localparam int VAL_W   = 12;
	localparam int SIZE_W  = 11;
	localparam int COORD_W = 10;
	localparam int CFG_IDX_W = 1;

	localparam logic OP_FILL = 1'b0;
	localparam logic OP_TEST = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 1'b1;

	localparam logic DIV_TILE = 1'b0;
	localparam logic DIV_ROW  = 1'b1;

	typedef struct packed {
		logic [VAL_W-1:0] quo;
		logic [VAL_W-1:0] prod;
		logic [VAL_W-1:0] rem;
	} div_res_t;

endpackage

@@ rtl/brft_cdiv.sv @@
module brft_cdiv
	import brft_pkg::*;
#(
	parameter int DIV_A = TILE_WORDS_DEF,
	parameter int DIV_B = WORD_BITS_DEF
) (
	input  logic             clk,
	input  logic             sel,
	input  logic [VAL_W-1:0] val,
	output div_res_t         res
);

	localparam int LA = $clog2(DIV_A);
	localparam int SA = VAL_W + LA;
	localparam int MA = ((1 << SA) + DIV_A - 1) / DIV_A;
	localparam int LB = $clog2(DIV_B);
	localparam int SB = VAL_W + LB;
	localparam int MB = ((1 << SB) + DIV_B - 1) / DIV_B;
	localparam int PW = 2 * VAL_W + 1;

	logic [PW-1:0]    pa_c, pb_c;
	logic [VAL_W-1:0] q_c;
	logic [VAL_W-1:0] q_s1, v_s1;
	logic             sel_s1;
	logic [VAL_W-1:0] prod_c;

	assign pa_c = PW'(val) * PW'(MA);
	assign pb_c = PW'(val) * PW'(MB);
	assign q_c  = (sel == DIV_ROW) ? VAL_W'(pb_c >> SB) : VAL_W'(pa_c >> SA);

	assign prod_c = (sel_s1 == DIV_ROW) ? VAL_W'(q_s1 * VAL_W'(DIV_B))
	                                    : VAL_W'(q_s1 * VAL_W'(DIV_A));

	always_ff @(posedge clk) begin
		q_s1     <= q_c;
		v_s1     <= val;
		sel_s1   <= sel;
		res.quo  <= q_s1;
		res.prod <= prod_c;
		res.rem  <= v_s1 - prod_c;
	end

endmodule

@@ rtl/bitmap_rect_fill_and_test_top.sv @@
// Channel   Direction  Handshake            Payload
// in        input      in_valid/in_ready    opcode min_x min_y end_x end_y cell_value
// out       output     out_valid/out_ready  found range_error
// cfg       input      cfg_write            cfg_index cfg_data
//
// A transaction visits one word per column in each tile row it spans (columns times tile rows
// spanned); empty or rejected rectangles skip that pass. The word memory, one word a cycle, sets the pace.
// Setup runs the grid sizes and row bounds through one shared divide-by-constant unit.
// arst_n clears the sequencer, the output valid and both size registers; grid words stay undefined.
// A finished result waits in the output register; a new transaction is taken meanwhile.
module bitmap_rect_fill_and_test_top
	import brft_pkg::*;
#(
	parameter int WORD_BITS  = WORD_BITS_DEF,
	parameter int TILE_WORDS = TILE_WORDS_DEF,
	parameter int GRID_MAX_X = GRID_MAX_X_DEF,
	parameter int GRID_MAX_Y = GRID_MAX_Y_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [SIZE_W-1:0]    cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 opcode,
	input  logic [COORD_W-1:0]   min_x,
	input  logic [COORD_W-1:0]   min_y,
	input  logic [SIZE_W-1:0]    end_x,
	input  logic [SIZE_W-1:0]    end_y,
	input  logic                 cell_value,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 found,
	output logic                 range_error
);

	localparam int CAP_X = (GRID_MAX_X / TILE_WORDS) * TILE_WORDS;
	localparam int CAP_Y = (GRID_MAX_Y / WORD_BITS) * WORD_BITS;
	localparam int DEPTH = CAP_X * (CAP_Y / WORD_BITS);
	localparam int AW    = $clog2(DEPTH);
	localparam int WW    = $clog2(CAP_X + 1);
	localparam int HW    = $clog2(CAP_Y + 1);
	localparam int TYW   = $clog2(CAP_Y / WORD_BITS + 1);
	localparam int BW    = $clog2(WORD_BITS);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_W     = 4'd1;
	localparam logic [3:0] ST_H     = 4'd2;
	localparam logic [3:0] ST_Y0    = 4'd3;
	localparam logic [3:0] ST_Y1    = 4'd4;
	localparam logic [3:0] ST_CHK   = 4'd5;
	localparam logic [3:0] ST_Y1R   = 4'd6;
	localparam logic [3:0] ST_RUN   = 4'd7;
	localparam logic [3:0] ST_DRAIN = 4'd8;
	localparam logic [3:0] ST_DONE  = 4'd9;

	logic [3:0]          state_q;
	logic [SIZE_W-1:0]   gw_q, gh_q;
	logic                out_valid_q, res_found_q, res_err_q;
	logic                op_q, val_q;
	logic [COORD_W-1:0]  x0_q, y0_q, x_q;
	logic [SIZE_W-1:0]   x1_q, y1_q;
	logic [WW-1:0]       w_q;
	logic [HW-1:0]       h_q;
	logic [TYW-1:0]      ty_q, ty0_q, ty1_q;
	logic [BW-1:0]       lo0_q, hi1_q;
	logic [AW-1:0]       row_q;
	logic                found_q, err_q;
	logic                wr_s1, tst_s1;
	logic [AW-1:0]       addr_s1;
	logic [WORD_BITS-1:0] mask_s1, rd_q;
	logic [WORD_BITS-1:0] mem [DEPTH];

	logic                div_sel;
	logic [VAL_W-1:0]    div_val;
	div_res_t            div_res;
	logic                empty_c, bad_c, last_x_c, done_go_c, hit_c;
	logic [BW-1:0]       lo_c, hi_c;
	logic [WORD_BITS-1:0] mask_c, new_word_c;
	logic [AW-1:0]       addr_c;

	brft_cdiv #(
		.DIV_A(TILE_WORDS),
		.DIV_B(WORD_BITS)
	) u_cdiv (
		.clk(clk),
		.sel(div_sel),
		.val(div_val),
		.res(div_res)
	);

	always_comb begin
		div_sel = DIV_ROW;
		div_val = VAL_W'(y0_q);
		case (state_q)
			ST_W: begin
				div_sel = DIV_TILE;
				div_val = VAL_W'(gw_q) + VAL_W'(TILE_WORDS - 1);
			end
			ST_H: begin
				div_val = VAL_W'(gh_q) + VAL_W'(WORD_BITS - 1);
			end
			ST_Y1: begin
				div_val = VAL_W'(y1_q) - VAL_W'(1);
			end
			default: begin
				div_val = VAL_W'(y0_q);
			end
		endcase
	end

	assign in_ready    = (state_q == ST_IDLE);
	assign out_valid   = out_valid_q;
	assign found       = res_found_q;
	assign range_error = res_err_q;

	assign empty_c = (x1_q == SIZE_W'(x0_q)) || (y1_q == SIZE_W'(y0_q));
	assign bad_c   = (x1_q < SIZE_W'(x0_q)) || (y1_q < SIZE_W'(y0_q))
	              || (32'(x1_q) > 32'(w_q)) || (32'(y1_q) > 32'(h_q));

	assign lo_c   = (ty_q == ty0_q) ? lo0_q : '0;
	assign hi_c   = (ty_q == ty1_q) ? hi1_q : BW'(WORD_BITS - 1);
	assign mask_c = ({WORD_BITS{1'b1}} << lo_c)
	              & ({WORD_BITS{1'b1}} >> (BW'(WORD_BITS - 1) - hi_c));
	assign addr_c = row_q + AW'(x_q);

	assign last_x_c   = ((SIZE_W'(x_q) + SIZE_W'(1)) == x1_q);
	assign done_go_c  = !out_valid_q || out_ready;
	assign new_word_c = val_q ? (rd_q | mask_s1) : (rd_q & ~mask_s1);
	assign hit_c      = val_q ? |(rd_q & mask_s1) : |(~rd_q & mask_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			gw_q        <= '0;
			gh_q        <= '0;
			out_valid_q <= 1'b0;
			wr_s1       <= 1'b0;
			tst_s1      <= 1'b0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					CFG_GRID_WIDTH:  gw_q <= cfg_data;
					CFG_GRID_HEIGHT: gh_q <= cfg_data;
					default: ;
				endcase
			end
			wr_s1  <= (state_q == ST_RUN) && (op_q == OP_FILL);
			tst_s1 <= (state_q == ST_RUN) && (op_q == OP_TEST);
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE:  if (in_valid) state_q <= ST_W;
				ST_W:     state_q <= ST_H;
				ST_H:     state_q <= ST_Y0;
				ST_Y0:    state_q <= ST_Y1;
				ST_Y1:    state_q <= ST_CHK;
				ST_CHK:   state_q <= (empty_c || bad_c) ? ST_DONE : ST_Y1R;
				ST_Y1R:   state_q <= ST_RUN;
				ST_RUN:   if (last_x_c && (ty_q == ty1_q)) state_q <= ST_DRAIN;
				ST_DRAIN: state_q <= ST_DONE;
				ST_DONE: begin
					if (done_go_c) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (tst_s1 && hit_c) begin
			found_q <= 1'b1;
		end
		case (state_q)
			ST_IDLE: begin
				op_q    <= opcode;
				val_q   <= cell_value;
				x0_q    <= min_x;
				y0_q    <= min_y;
				x1_q    <= end_x;
				y1_q    <= end_y;
				found_q <= 1'b0;
				err_q   <= 1'b0;
			end
			ST_Y0: begin
				w_q <= (32'(div_res.prod) > 32'(CAP_X)) ? WW'(CAP_X) : WW'(div_res.prod);
			end
			ST_Y1: begin
				h_q <= (32'(div_res.prod) > 32'(CAP_Y)) ? HW'(CAP_Y) : HW'(div_res.prod);
			end
			ST_CHK: begin
				ty_q  <= TYW'(div_res.quo);
				ty0_q <= TYW'(div_res.quo);
				lo0_q <= BW'(div_res.rem);
				err_q <= !empty_c && bad_c;
			end
			ST_Y1R: begin
				ty1_q <= TYW'(div_res.quo);
				hi1_q <= BW'(div_res.rem);
				row_q <= AW'(ty_q) * AW'(w_q);
				x_q   <= x0_q;
			end
			ST_RUN: begin
				if (last_x_c) begin
					x_q   <= x0_q;
					ty_q  <= ty_q + TYW'(1);
					row_q <= row_q + AW'(w_q);
				end else begin
					x_q <= x_q + COORD_W'(1);
				end
			end
			ST_DONE: begin
				if (done_go_c) begin
					res_found_q <= (op_q == OP_TEST) && found_q && !err_q;
					res_err_q   <= err_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		addr_s1 <= addr_c;
		mask_s1 <= mask_c;
		rd_q    <= mem[addr_c];
		if (wr_s1) begin
			mem[addr_s1] <= new_word_c;
		end
	end

endmodule
